>>> design/fsd_pkg.sv
// Shared types and codes for the frame store shape drawer.
package fsd_pkg;

  localparam int COORD_W = 8;
  localparam int COLOR_W = 16;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  // Command modes carried in the input tuser field
  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL = 3'd0,
    MODE_HLINE = 3'd1,
    MODE_VLINE = 3'd2,
    MODE_RECT  = 3'd3,
    MODE_CLEAR = 3'd4,
    MODE_READ  = 3'd5
  } mode_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_t;

  // Work kinds handed from the front end to the back end
  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_FILL = 2'd1,
    JOB_RECT = 2'd2,
    JOB_READ = 2'd3
  } job_op_t;

  // One classified command: a box to scan plus what to write in it
  typedef struct packed {
    job_op_t             op;
    logic [COORD_W-1:0]  x_lo;
    logic [COORD_W-1:0]  x_hi;
    logic [COORD_W-1:0]  y_lo;
    logic [COORD_W-1:0]  y_hi;
    logic [COORD_W-1:0]  x_cut;
    logic [COORD_W-1:0]  y_cut;
    logic                fill;
    logic [COLOR_W-1:0]  color;
    status_t             status;
  } job_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_SCAN = 2'd0,
    BK_IDLE = 2'd1,
    BK_READ = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

endpackage

>>> design/framebuffer_shape_drawer.sv
// Each command scans the pixels of its box: one pixel, the edge-cut line, the bounding box for
// a rectangle, the whole W*H store for clear; refused, rejected or unused commands scan none;
// read fetches a single stored word.
// Throughput: one pixel per cycle, set by the single write port of the frame store;
// a two-word queue lets new commands arrive while a long fill runs.
// Reset: synchronous, active low; W*H-word store clear with in_tready low; enable resets to 0.
module framebuffer_shape_drawer #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // display_enabled
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,      // x_first, y_first, x_second, y_second, length,
                                      // color, fill, zero pad
  input  logic [2:0]   in_tuser,      // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata      // status, read_color, zero pad
);
  import fsd_pkg::*;

  logic                init_busy;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  job_t                push_job, pop_job;
  logic [STAT_W-1:0]   out_status;
  logic [COLOR_W-1:0]  out_color;

  // Classify commands
  fsd_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .init_busy   (init_busy),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .mode        (in_tuser),
    .x_first     (in_tdata[7:0]),
    .y_first     (in_tdata[15:8]),
    .x_second    (in_tdata[23:16]),
    .y_second    (in_tdata[31:24]),
    .length      (in_tdata[39:32]),
    .color       (in_tdata[55:40]),
    .fill        (in_tdata[56]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  // Decouple front and back
  fsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Execute jobs against the frame store
  fsd_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_busy  (init_busy),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_color  (out_color)
  );

  assign out_tdata = {6'b0, out_color, out_status};

`ifndef SYNTHESIS
  // No command taken while the store is being cleared
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !in_tready)
    else $error("command accepted during clearing pass");

  // No result appears during the clearing pass
  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !out_tvalid)
    else $error("result during clearing pass");

  // Status carries only the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status != 2'd3))
    else $error("undefined status code");

  // Clearing pass never restarts after it ends
  a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
    !init_busy |=> !init_busy)
    else $error("clearing pass restarted");
`endif

endmodule

>>> design/fsd_front.sv
// Front end: holds the enable register, clamps and classifies each command word.
module fsd_front #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic                         init_busy,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fsd_pkg::MODE_W-1:0]   mode,
  input  logic [fsd_pkg::COORD_W-1:0]  x_first,
  input  logic [fsd_pkg::COORD_W-1:0]  y_first,
  input  logic [fsd_pkg::COORD_W-1:0]  x_second,
  input  logic [fsd_pkg::COORD_W-1:0]  y_second,
  input  logic [fsd_pkg::COORD_W-1:0]  length,
  input  logic [fsd_pkg::COLOR_W-1:0]  color,
  input  logic                         fill,
  output logic                         push_valid,
  input  logic                         push_ready,
  output fsd_pkg::job_t                push_job
);
  import fsd_pkg::*;

  localparam logic [COORD_W-1:0] XMAX  = COORD_W'(DISPLAY_WIDTH - 1);
  localparam logic [COORD_W-1:0] YMAX  = COORD_W'(DISPLAY_HEIGHT - 1);
  localparam logic [COORD_W-1:0] XLIM  = COORD_W'(DISPLAY_WIDTH - 2);
  localparam logic [COORD_W-1:0] YLIM  = COORD_W'(DISPLAY_HEIGHT - 2);
  localparam logic [COORD_W:0]   WIDTH9  = (COORD_W+1)'(DISPLAY_WIDTH);
  localparam logic [COORD_W:0]   HEIGHT9 = (COORD_W+1)'(DISPLAY_HEIGHT);

  logic                display_enabled_r;
  logic [COORD_W-1:0]  cx, cy, cx2, cy2;
  logic [COORD_W-1:0]  xl, xh, yl, yh;
  logic [COORD_W:0]    hsum, vsum;
  logic                hcut, vcut;
  logic [COORD_W-1:0]  hlast, vlast;
  job_t                job;

  // Hold the enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_enabled_r <= 1'b0;
    end else if (cfg_wr_en) begin
      display_enabled_r <= cfg_wr_data;
    end
  end

  // Clamp coordinates, order the corners and cut line lengths
  always_comb begin
    cx  = ({1'b0, x_first}  >= WIDTH9)  ? XMAX : x_first;
    cy  = ({1'b0, y_first}  >= HEIGHT9) ? YMAX : y_first;
    cx2 = ({1'b0, x_second} >= WIDTH9)  ? XMAX : x_second;
    cy2 = ({1'b0, y_second} >= HEIGHT9) ? YMAX : y_second;
    xl  = (cx <= cx2) ? cx  : cx2;
    xh  = (cx <= cx2) ? cx2 : cx;
    yl  = (cy <= cy2) ? cy  : cy2;
    yh  = (cy <= cy2) ? cy2 : cy;
    hsum  = {1'b0, length} + {1'b0, cx};
    vsum  = {1'b0, length} + {1'b0, cy};
    hcut  = (hsum >= WIDTH9);
    vcut  = (vsum >= HEIGHT9);
    hlast = hcut ? XLIM : COORD_W'(hsum - (COORD_W+1)'(1));
    vlast = vcut ? YLIM : COORD_W'(vsum - (COORD_W+1)'(1));
  end

  // Classify the command into one scan job
  always_comb begin
    job.op     = JOB_NONE;
    job.x_lo   = cx;
    job.x_hi   = cx;
    job.y_lo   = cy;
    job.y_hi   = cy;
    job.x_cut  = XLIM;
    job.y_cut  = YLIM;
    job.fill   = fill;
    job.color  = color;
    job.status = ST_OK;
    unique case (mode)
      MODE_PIXEL: begin
        if (!display_enabled_r) job.status = ST_DISABLED;
        else                    job.op     = JOB_FILL;
      end
      MODE_HLINE: begin
        if (length == '0)                 job.status = ST_ZERO_LEN;
        else if (!display_enabled_r)      job.status = ST_DISABLED;
        else if (!(hcut && cx == XMAX)) begin
          job.op   = JOB_FILL;
          job.x_hi = hlast;
        end
      end
      MODE_VLINE: begin
        if (length == '0)                 job.status = ST_ZERO_LEN;
        else if (!display_enabled_r)      job.status = ST_DISABLED;
        else if (!(vcut && cy == YMAX)) begin
          job.op   = JOB_FILL;
          job.y_hi = vlast;
        end
      end
      MODE_RECT: begin
        if (!display_enabled_r) begin
          job.status = ST_DISABLED;
        end else begin
          job.op    = JOB_RECT;
          job.x_lo  = xl;
          job.x_hi  = xh;
          job.y_lo  = yl;
          job.y_hi  = yh;
          job.x_cut = (xh == XMAX) ? XLIM : xh;
          job.y_cut = (yh == YMAX) ? YLIM : yh;
        end
      end
      MODE_CLEAR: begin
        if (!display_enabled_r) begin
          job.status = ST_DISABLED;
        end else begin
          job.op    = JOB_FILL;
          job.x_lo  = '0;
          job.x_hi  = XMAX;
          job.y_lo  = '0;
          job.y_hi  = YMAX;
          job.color = '0;
        end
      end
      MODE_READ: begin
        job.op = JOB_READ;
      end
      default: begin
        job.op = JOB_NONE;
      end
    endcase
  end

  // Accept only once the power-up clear is over and the queue has room
  assign in_ready   = !init_busy && push_ready;
  assign push_valid = in_valid && !init_busy;
  assign push_job   = job;

endmodule

>>> design/fsd_queue.sv
// Two-entry job queue between the front end and the back end.
module fsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fsd_pkg::job_t  push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fsd_pkg::job_t  pop_job
);
  import fsd_pkg::*;

  job_t        slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      count_r <= count_r + 2'd1;
      else if (!do_push && do_pop) count_r <= count_r - 2'd1;
    end
  end

endmodule

>>> design/fsd_back.sv
// Back end: owns the frame store, scans each job box one pixel per cycle.
module fsd_back #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         init_busy,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  fsd_pkg::job_t                pop_job,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fsd_pkg::STAT_W-1:0]   out_status,
  output logic [fsd_pkg::COLOR_W-1:0]  out_color
);
  import fsd_pkg::*;

  localparam int DEPTH  = DISPLAY_WIDTH * DISPLAY_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [COORD_W-1:0] XMAX = COORD_W'(DISPLAY_WIDTH - 1);
  localparam logic [COORD_W-1:0] YMAX = COORD_W'(DISPLAY_HEIGHT - 1);
  localparam logic [ADDR_W-1:0]  ROW_STEP = ADDR_W'(DISPLAY_WIDTH);

  logic [COLOR_W-1:0]  store [DEPTH];
  logic [COLOR_W-1:0]  rdata_r;

  back_state_t         state_r, state_nxt;
  job_t                job_r, job_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [ADDR_W-1:0]   row_base_r, row_base_nxt;
  logic                init_r, init_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [COLOR_W-1:0]  out_color_r, out_color_nxt;

  logic [ADDR_W-1:0]   addr;
  logic                wr_en;
  logic                on_h, on_v, inner, last_px;

  assign addr = row_base_r + ADDR_W'(col_r);

  // Pick which pixels of the box the job writes
  always_comb begin
    on_h  = (row_r == job_r.y_lo || row_r == job_r.y_hi) && (col_r <= job_r.x_cut);
    on_v  = (col_r == job_r.x_lo || col_r == job_r.x_hi) && (row_r <= job_r.y_cut);
    inner = job_r.fill && (col_r != job_r.x_lo) && (col_r != job_r.x_hi)
            && (row_r != job_r.y_lo) && (row_r != job_r.y_hi);
    last_px = (col_r == job_r.x_hi) && (row_r == job_r.y_hi);
    wr_en = 1'b0;
    if (state_r == BK_SCAN) begin
      unique case (job_r.op)
        JOB_FILL: wr_en = 1'b1;
        JOB_RECT: wr_en = on_h || on_v || inner;
        default:  wr_en = 1'b0;
      endcase
    end
  end

  // Frame store: one write and one registered read per cycle, both at the same address
  always_ff @(posedge clk) begin
    if (wr_en) store[addr] <= job_r.color;
    rdata_r <= store[addr];
  end

  // Sequence jobs and load the result register
  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    row_base_nxt   = row_base_r;
    init_nxt       = init_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_color_nxt  = out_color_r;
    pop_ready      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_nxt      = pop_job;
          col_nxt      = pop_job.x_lo;
          row_nxt      = pop_job.y_lo;
          row_base_nxt = ADDR_W'(pop_job.y_lo * DISPLAY_WIDTH);
          unique case (pop_job.op)
            JOB_FILL, JOB_RECT: state_nxt = BK_SCAN;
            JOB_READ:           state_nxt = BK_READ;
            default:            state_nxt = BK_DONE;
          endcase
        end
      end
      BK_SCAN: begin
        if (last_px) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? BK_IDLE : BK_DONE;
        end else if (col_r == job_r.x_hi) begin
          col_nxt      = job_r.x_lo;
          row_nxt      = row_r + COORD_W'(1);
          row_base_nxt = row_base_r + ROW_STEP;
        end else begin
          col_nxt = col_r + COORD_W'(1);
        end
      end
      BK_READ: begin
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = job_r.status;
          out_color_nxt  = (job_r.op == JOB_READ) ? rdata_r : '0;
          state_nxt      = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Hold the sequencer registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_SCAN;
      init_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      job_r.op     <= JOB_FILL;
      job_r.x_lo   <= '0;
      job_r.x_hi   <= XMAX;
      job_r.y_lo   <= '0;
      job_r.y_hi   <= YMAX;
      job_r.x_cut  <= '0;
      job_r.y_cut  <= '0;
      job_r.fill   <= 1'b0;
      job_r.color  <= '0;
      job_r.status <= ST_OK;
      col_r        <= '0;
      row_r        <= '0;
      row_base_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      job_r       <= job_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_base_r  <= row_base_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_color_r  <= out_color_nxt;
  end

  assign init_busy  = init_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_color  = out_color_r;

endmodule
